// ----- hw/rtl/gasp_pkg.sv -----
// ----------------------------------------------------------------------------
// gasp_pkg
// shared types and constants for the grid path search block
// ----------------------------------------------------------------------------
package gasp_pkg;

   localparam int MaxWidth   = 64;
   localparam int MaxHeight  = 64;
   localparam int XBits      = 6;
   localparam int YBits      = 6;
   localparam int AddrBits   = XBits + YBits;
   localparam int CellCount  = MaxWidth * MaxHeight;
   localparam int CountBits  = AddrBits + 1;

   localparam logic [1:0] ReqLoad   = 2'd0;
   localparam logic [1:0] ReqSearch = 2'd1;
   localparam logic [1:0] ReqRead   = 2'd2;

   localparam logic [2:0] CsrWidth  = 3'd0;
   localparam logic [2:0] CsrHeight = 3'd1;
   localparam logic [2:0] CsrDiag   = 3'd2;
   localparam logic [2:0] CsrWDir   = 3'd3;
   localparam logic [2:0] CsrWDiag  = 3'd4;

   localparam logic [1:0] StUnvisited = 2'd0;
   localparam logic [1:0] StOpen      = 2'd1;
   localparam logic [1:0] StClosed    = 2'd2;

   localparam logic [4:0] CostStraight = 5'd10;
   localparam logic [4:0] CostDiagonal = 5'd14;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_SEED,
      S_SCAN_RD,
      S_SCAN_CELL,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CLOSE,
      S_CUR_RD,
      S_CUR_WAIT,
      S_NB_GEN,
      S_NB_WAIT,
      S_NB_EVAL,
      S_PATH_RD,
      S_PATH_WAIT,
      S_REV_RD,
      S_REV_WAIT,
      S_REV_WR,
      S_READ_WAIT,
      S_RESPOND
   } state_type;

   // move offsets, direction order L,T,R,B,LT,RT,RB,LB
   function automatic logic signed [1:0] move_dx(input logic [2:0] d);
      case (d)
         3'd0, 3'd4, 3'd7: move_dx = -2'sd1;
         3'd2, 3'd5, 3'd6: move_dx = 2'sd1;
         default:          move_dx = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] move_dy(input logic [2:0] d);
      case (d)
         3'd1, 3'd4, 3'd5: move_dy = -2'sd1;
         3'd3, 3'd6, 3'd7: move_dy = 2'sd1;
         default:          move_dy = 2'sd0;
      endcase
   endfunction

endpackage

// ----- hw/rtl/grid_astar_path_search.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_search
// a* search on a 64 x 64 occupancy grid with path read-back
// ----------------------------------------------------------------------------
// after reset the block holds busy while it sweeps the blocked map and the
// cell status memory to free and unvisited. a load transaction is written at
// its accepting edge, gives no result and leaves busy low. a search
// transaction first sweeps the cell status memory. then, for each closed
// cell, it scans the open list one entry at a time (entry read, node read,
// compare), removes the winner by shifting the later entries down and
// relaxes up to eight neighbours (generate, wait, evaluate each). it then
// builds the path from the parent links and reverses it in place. a read
// transaction holds busy for one cycle; its result is registered from the
// path memory read into the rsp_ registers. each result is on the rsp_
// ports for one cycle marked by rsp_valid; the receiver cannot stall it.
// busy drops in the cycle the result appears, so the next transaction can
// be accepted at the edge that ends that cycle.
module grid_astar_path_search import gasp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [XBits-1:0]     req_cell_x,
   input  logic [YBits-1:0]     req_cell_y,
   input  logic                 req_cell_blocked,
   input  logic [XBits-1:0]     req_start_x,
   input  logic [YBits-1:0]     req_start_y,
   input  logic [XBits-1:0]     req_target_x,
   input  logic [YBits-1:0]     req_target_y,
   input  logic [11:0]          req_path_index,
   output logic                 rsp_valid,
   output logic                 rsp_target_found,
   output logic [12:0]          rsp_path_length,
   output logic [XBits-1:0]     rsp_step_x,
   output logic [YBits-1:0]     rsp_step_y,
   output logic                 rsp_index_valid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data
);

   // configuration registers
   logic [6:0] grid_width_ff, grid_height_ff;
   logic       diag_ff;
   logic [7:0] wdir_ff, wdiag_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd64;
         grid_height_ff <= 7'd64;
         diag_ff        <= 1'b1;
         wdir_ff        <= 8'd10;
         wdiag_ff       <= 8'd14;
      end else if (csr_valid) begin
         case (csr_index)
            CsrWidth:  grid_width_ff  <= csr_data[6:0];
            CsrHeight: grid_height_ff <= csr_data[6:0];
            CsrDiag:   diag_ff        <= csr_data[0];
            CsrWDir:   wdir_ff        <= csr_data;
            CsrWDiag:  wdiag_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped grid size
   logic [6:0] w_eff, h_eff;
   always_comb begin
      w_eff = (grid_width_ff == 7'd0) ? 7'd1 :
              (grid_width_ff > 7'(MaxWidth)) ? 7'(MaxWidth) : grid_width_ff;
      h_eff = (grid_height_ff == 7'd0) ? 7'd1 :
              (grid_height_ff > 7'(MaxHeight)) ? 7'(MaxHeight) : grid_height_ff;
   end

   // ------------------------------------------------------------------
   // memories: one write, one registered read each
   // ------------------------------------------------------------------
   logic                blk_mem  [CellCount];
   logic [1:0]          st_mem   [CellCount];
   logic [34:0]         node_mem [CellCount];   // g, h, parent direction
   logic [AddrBits-1:0] open_mem [CellCount];
   logic [AddrBits-1:0] path_mem [CellCount];

   logic                blk_we, st_we, node_we, open_we, path_we;
   logic [AddrBits-1:0] blk_wa, st_wa, node_wa, open_wa, path_wa;
   logic                blk_wd;
   logic [1:0]          st_wd;
   logic [34:0]         node_wd;
   logic [AddrBits-1:0] open_wd, path_wd;
   logic [AddrBits-1:0] blk_ra, st_ra, node_ra, open_ra, path_ra;
   logic                blk_rd;
   logic [1:0]          st_rd;
   logic [34:0]         node_rd;
   logic [AddrBits-1:0] open_rd, path_rd;

   // blocked map clears by sweep after reset along with status
   always_ff @(posedge clock) begin
      if (blk_we) blk_mem[blk_wa] <= blk_wd;
      blk_rd <= blk_mem[blk_ra];
      if (st_we) st_mem[st_wa] <= st_wd;
      st_rd <= st_mem[st_ra];
      if (node_we) node_mem[node_wa] <= node_wd;
      node_rd <= node_mem[node_ra];
      if (open_we) open_mem[open_wa] <= open_wd;
      open_rd <= open_mem[open_ra];
      if (path_we) path_mem[path_wa] <= path_wd;
      path_rd <= path_mem[path_ra];
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic                init_ff, init_in;       // reset clear pass of blocked map
   logic [CountBits-1:0] cnt_ff, cnt_in;        // sweep / shift / path counter
   logic [CountBits-1:0] open_cnt_ff, open_cnt_in;
   logic [CountBits-1:0] len_ff, len_in;
   logic                found_ff, found_in;
   logic [CountBits-1:0] scan_ff, scan_in;
   logic [CountBits-1:0] best_ff, best_in;
   logic [16:0]         fb_ff, fb_in;
   logic [15:0]         hb_ff, hb_in;
   logic [AddrBits-1:0] cand_ff, cand_in;
   logic [AddrBits-1:0] cur_ff, cur_in;
   logic [15:0]         gcur_ff, gcur_in;
   logic [2:0]          dir_ff, dir_in;
   logic [AddrBits-1:0] nb_ff, nb_in;
   logic [AddrBits-1:0] s_ff, s_in, t_ff, t_in;
   logic [11:0]         ridx_ff, ridx_in;
   logic [AddrBits-1:0] tmp_ff, tmp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [XBits-1:0]    rsx_ff, rsx_in;
   logic [YBits-1:0]    rsy_ff, rsy_in;
   logic                riv_ff, riv_in;
   logic [15:0]         prod_ff, prod_in;       // registered heuristic product

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         open_cnt_ff  <= '0;
         len_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         open_cnt_ff  <= open_cnt_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff <= scan_in;  best_ff <= best_in;  fb_ff <= fb_in;  hb_ff <= hb_in;
      cand_ff <= cand_in;  cur_ff <= cur_in;    gcur_ff <= gcur_in;
      dir_ff <= dir_in;    nb_ff <= nb_in;
      s_ff <= s_in;        t_ff <= t_in;
      ridx_ff <= ridx_in;  tmp_ff <= tmp_in;
      rsx_ff <= rsx_in;    rsy_ff <= rsy_in;    riv_ff <= riv_in;
      prod_ff <= prod_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_found = found_ff;
   assign rsp_path_length  = len_ff;
   assign rsp_step_x       = rsx_ff;
   assign rsp_step_y       = rsy_ff;
   assign rsp_index_valid  = riv_ff;

   // heuristic of a cell relative to the target, saturated
   function automatic logic [15:0] heur(input logic [AddrBits-1:0] c,
                                         input logic [AddrBits-1:0] tc,
                                         input logic dg, input logic [7:0] wd,
                                         input logic [7:0] wg);
      logic [XBits-1:0] dx, dy;
      logic [XBits:0]   m;
      logic [16:0]      p;
      begin
         dx = (c[XBits-1:0] > tc[XBits-1:0]) ? c[XBits-1:0] - tc[XBits-1:0]
                                             : tc[XBits-1:0] - c[XBits-1:0];
         dy = (c[AddrBits-1:XBits] > tc[AddrBits-1:XBits]) ?
              c[AddrBits-1:XBits] - tc[AddrBits-1:XBits] :
              tc[AddrBits-1:XBits] - c[AddrBits-1:XBits];
         if (dg) begin
            m = (dx > dy) ? {1'b0, dx} : {1'b0, dy};
            p = 17'(m * wg);
         end else begin
            m = {1'b0, dx} + {1'b0, dy};
            p = 17'(m * wd);
         end
         heur = (p > 17'd65535) ? 16'hFFFF : p[15:0];
      end
   endfunction

   // neighbour generation
   logic signed [7:0] nx_s, ny_s;
   logic              nb_in_grid;
   logic [15:0]       g_new;
   logic [16:0]       g_sum, f_cand;

   always_comb begin
      nx_s = $signed({2'b00, cur_ff[XBits-1:0]}) + 8'(move_dx(dir_ff));
      ny_s = $signed({2'b00, cur_ff[AddrBits-1:XBits]}) + 8'(move_dy(dir_ff));
      nb_in_grid = !nx_s[7] && !ny_s[7] && (nx_s < $signed({1'b0, w_eff}))
                   && (ny_s < $signed({1'b0, h_eff}));
      g_sum = {1'b0, gcur_ff} + 17'(dir_ff[2] ? CostDiagonal : CostStraight);
      g_new = g_sum[16] ? 16'hFFFF : g_sum[15:0];
      f_cand = {1'b0, node_rd[34:19]} + {1'b0, node_rd[18:3]};
   end

   // path back-step
   logic signed [7:0] px_s, py_s;
   always_comb begin
      px_s = $signed({2'b00, cand_ff[XBits-1:0]}) - 8'(move_dx(node_rd[2:0]));
      py_s = $signed({2'b00, cand_ff[AddrBits-1:XBits]}) - 8'(move_dy(node_rd[2:0]));
   end

   always_comb begin
      state_in = state_ff;  init_in = init_ff;   cnt_in = cnt_ff;
      open_cnt_in = open_cnt_ff;  len_in = len_ff;  found_in = found_ff;
      scan_in = scan_ff;  best_in = best_ff;  fb_in = fb_ff;  hb_in = hb_ff;
      cand_in = cand_ff;  cur_in = cur_ff;  gcur_in = gcur_ff;  dir_in = dir_ff;
      nb_in = nb_ff;  s_in = s_ff;  t_in = t_ff;
      ridx_in = ridx_ff;  tmp_in = tmp_ff;
      rsp_valid_in = 1'b0;  rsx_in = rsx_ff;  rsy_in = rsy_ff;  riv_in = riv_ff;
      prod_in = heur(nb_ff, t_ff, diag_ff, wdir_ff, wdiag_ff);
      blk_we = 1'b0;  blk_wa = '0;  blk_wd = 1'b0;  blk_ra = '0;
      st_we = 1'b0;   st_wa = '0;   st_wd = StUnvisited;  st_ra = '0;
      node_we = 1'b0; node_wa = '0; node_wd = '0;  node_ra = '0;
      open_we = 1'b0; open_wa = '0; open_wd = '0;  open_ra = '0;
      path_we = 1'b0; path_wa = '0; path_wd = '0;  path_ra = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ridx_in  = req_path_index;
               s_in = {req_start_y, req_start_x};
               t_in = {req_target_y, req_target_x};
               case (req_type)
                  ReqLoad: begin
                     blk_we = 1'b1;
                     blk_wa = {req_cell_y, req_cell_x};
                     blk_wd = req_cell_blocked;
                  end
                  ReqSearch: begin
                     found_in = 1'b0;  len_in = '0;  open_cnt_in = '0;
                     cnt_in = '0;
                     state_in = S_CLEAR;
                  end
                  ReqRead: begin
                     path_ra = req_path_index;
                     state_in = S_READ_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            st_we = 1'b1;  st_wa = cnt_ff[AddrBits-1:0];  st_wd = StUnvisited;
            if (init_ff) begin
               blk_we = 1'b1;  blk_wa = cnt_ff[AddrBits-1:0];  blk_wd = 1'b0;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CountBits'(CellCount - 1)) begin
               cnt_in = '0;
               if (init_ff) begin
                  init_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SEED;
               end
            end
         end
         S_SEED: begin
            if ((s_ff[XBits-1:0] >= w_eff[XBits:0])
                || (s_ff[AddrBits-1:XBits] >= h_eff[YBits:0])
                || (t_ff[XBits-1:0] >= w_eff[XBits:0])
                || (t_ff[AddrBits-1:XBits] >= h_eff[YBits:0])) begin
               state_in = S_RESPOND;
            end else begin
               node_we = 1'b1;  node_wa = s_ff;
               node_wd = {16'd0, heur(s_ff, t_ff, diag_ff, wdir_ff, wdiag_ff), 3'd0};
               st_we = 1'b1;  st_wa = s_ff;  st_wd = StOpen;
               open_we = 1'b1;  open_wa = '0;  open_wd = s_ff;
               open_cnt_in = CountBits'(1);
               scan_in = '0;
               state_in = S_SCAN_RD;
            end
         end
         // open list scan: read entry, read its node, compare
         S_SCAN_RD: begin
            if (open_cnt_ff == '0) begin
               state_in = S_RESPOND;
            end else begin
               open_ra = scan_ff[AddrBits-1:0];
               state_in = S_SCAN_CELL;
            end
         end
         S_SCAN_CELL: begin
            node_ra = open_rd;
            cand_in = open_rd;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if ((scan_ff == '0) || (f_cand < fb_ff) ||
                ((f_cand == fb_ff) && (node_rd[18:3] < hb_ff))) begin
               best_in = scan_ff;  fb_in = f_cand;  hb_in = node_rd[18:3];
               cur_in = cand_ff;   gcur_in = node_rd[34:19];
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff + 1'b1 == open_cnt_ff) begin
               cnt_in = best_in;
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         // remove the winner keeping list order
         S_SHIFT_RD: begin
            if (cnt_ff + 1'b1 >= open_cnt_ff) begin
               state_in = S_CLOSE;
            end else begin
               open_ra = cnt_ff[AddrBits-1:0] + 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            open_we = 1'b1;  open_wa = cnt_ff[AddrBits-1:0];  open_wd = open_rd;
            cnt_in = cnt_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_CLOSE: begin
            open_cnt_in = open_cnt_ff - 1'b1;
            st_we = 1'b1;  st_wa = cur_ff;  st_wd = StClosed;
            if (cur_ff == t_ff) begin
               found_in = 1'b1;
               cand_in = t_ff;
               state_in = S_PATH_RD;
            end else begin
               dir_in = '0;
               state_in = S_NB_GEN;
            end
         end
         S_NB_GEN: begin
            nb_in = {ny_s[YBits-1:0], nx_s[XBits-1:0]};
            if (nb_in_grid) begin
               st_ra = {ny_s[YBits-1:0], nx_s[XBits-1:0]};
               blk_ra = {ny_s[YBits-1:0], nx_s[XBits-1:0]};
               node_ra = {ny_s[YBits-1:0], nx_s[XBits-1:0]};
               state_in = S_NB_WAIT;
            end else if (dir_ff == (diag_ff ? 3'd7 : 3'd3)) begin
               scan_in = '0;
               state_in = S_SCAN_RD;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         // hold the neighbour reads while its heuristic is registered
         S_NB_WAIT: begin
            st_ra = nb_ff;
            blk_ra = nb_ff;
            node_ra = nb_ff;
            state_in = S_NB_EVAL;
         end
         S_NB_EVAL: begin
            if ((st_rd != StClosed) && !blk_rd &&
                ((st_rd == StUnvisited) || (g_new < node_rd[34:19]))) begin
               node_we = 1'b1;  node_wa = nb_ff;  node_wd = {g_new, prod_ff, dir_ff};
               if (st_rd != StOpen) begin
                  st_we = 1'b1;  st_wa = nb_ff;  st_wd = StOpen;
                  if (open_cnt_ff < CountBits'(CellCount)) begin
                     open_we = 1'b1;  open_wa = open_cnt_ff[AddrBits-1:0];
                     open_wd = nb_ff;
                     open_cnt_in = open_cnt_ff + 1'b1;
                  end
               end
            end
            if (dir_ff == (diag_ff ? 3'd7 : 3'd3)) begin
               scan_in = '0;
               state_in = S_SCAN_RD;
            end else begin
               dir_in = dir_ff + 1'b1;
               state_in = S_NB_GEN;
            end
         end
         // walk parents from the target back to the start
         S_PATH_RD: begin
            if ((cand_ff == s_ff) || (len_ff == CountBits'(CellCount))) begin
               cnt_in = '0;
               state_in = S_REV_RD;
            end else begin
               node_ra = cand_ff;
               state_in = S_PATH_WAIT;
            end
         end
         S_PATH_WAIT: begin
            path_we = 1'b1;  path_wa = len_ff[AddrBits-1:0];  path_wd = cand_ff;
            len_in = len_ff + 1'b1;
            if (px_s[7] || py_s[7] || (px_s >= 8'sd64) || (py_s >= 8'sd64)) begin
               cnt_in = '0;
               state_in = S_REV_RD;
            end else begin
               cand_in = {py_s[YBits-1:0], px_s[XBits-1:0]};
               state_in = S_PATH_RD;
            end
         end
         // reverse in place, one swap per pass through S_REV_RD, S_REV_WAIT, S_REV_WR, S_CUR_RD
         S_REV_RD: begin
            if (cnt_ff >= (len_ff >> 1)) begin
               state_in = S_RESPOND;
            end else begin
               path_ra = cnt_ff[AddrBits-1:0];
               state_in = S_REV_WAIT;
            end
         end
         S_REV_WAIT: begin
            tmp_in = path_rd;
            path_ra = 12'(len_ff - 1'b1 - cnt_ff);
            state_in = S_REV_WR;
         end
         S_REV_WR: begin
            path_we = 1'b1;  path_wa = cnt_ff[AddrBits-1:0];  path_wd = path_rd;
            cnt_in = cnt_ff + 1'b1;
            state_in = S_CUR_RD;
         end
         S_CUR_RD: begin
            path_we = 1'b1;  path_wa = 12'(len_ff - cnt_ff);  path_wd = tmp_ff;
            state_in = S_REV_RD;
         end
         S_READ_WAIT: begin
            if ({1'b0, ridx_ff} < len_ff) begin
               rsx_in = path_rd[XBits-1:0];  rsy_in = path_rd[AddrBits-1:XBits];
               riv_in = 1'b1;
            end else begin
               rsx_in = '0;  rsy_in = '0;  riv_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RESPOND: begin
            rsx_in = '0;  rsy_in = '0;  riv_in = 1'b0;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
